FILE: hdl/lzsr_pkg.sv
// ----------------------------------------------------------------------------
// lzsr_pkg: shared definitions for the longest zero-sum run block
// Sizes of the prefix-sum table and the token that moves along the cell row.
// ----------------------------------------------------------------------------
package lzsr_pkg;

  localparam int unsigned MaxLen      = 1024;
  localparam int unsigned ElementBits = 12;

  // Position of an element inside the array, and a length that can reach MaxLen.
  localparam int unsigned PosW = $clog2(MaxLen);
  localparam int unsigned LenW = $clog2(MaxLen + 1);
  // A prefix sum of up to MaxLen elements cannot overflow this width.
  localparam int unsigned SumW = ElementBits + PosW + 1;

  // One accepted element as it travels down the row of cells.
  typedef struct packed {
    logic                   vld;   // slot holds an element
    logic                   last;  // final element of the array
    logic                   ovf;   // array ran past MaxLen elements
    logic                   srch;  // prefix sum must be looked up in the table
    logic                   done;  // lookup resolved (hit or inserted)
    logic [LenW-1:0]        best;  // this element's candidate run length
    logic [PosW-1:0]        idx;   // element position
    logic signed [SumW-1:0] sum;   // prefix sum through this element
  } lzsr_token_t;

endpackage

FILE: hdl/lzsr_head.sv
// ----------------------------------------------------------------------------
// lzsr_head: input stage
// Accepts elements, keeps the running prefix sum, the position counter and the
// overflow flag, and launches one token per element into the cell row.
// ----------------------------------------------------------------------------
module lzsr_head (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  in_valid_i,
  input  logic signed [lzsr_pkg::ElementBits-1:0] element_i,
  input  logic                                  last_i,
  output lzsr_pkg::lzsr_token_t                 tok_o
);
  import lzsr_pkg::*;

  logic signed [SumW-1:0] sum_q, sum_d;
  logic [LenW-1:0]        idx_q, idx_d;
  logic                   ovf_q, ovf_d;
  lzsr_token_t            tok_q, tok_d;

  logic signed [SumW-1:0] sum_new;
  logic                   in_range;
  logic                   accept;

  assign accept   = in_valid_i && en_i;
  assign in_range = (idx_q < LenW'(MaxLen));
  assign sum_new  = sum_q + SumW'(element_i);

  always_comb begin
    sum_d = sum_q;
    idx_d = idx_q;
    ovf_d = ovf_q;
    tok_d = '0;
    if (accept) begin
      tok_d.vld  = 1'b1;
      tok_d.last = last_i;
      tok_d.idx  = idx_q[PosW-1:0];
      if (in_range) begin
        sum_d     = sum_new;
        idx_d     = LenW'(idx_q + 1'b1);
        tok_d.sum = sum_new;
        // A zero prefix sum means the whole array so far is a zero-sum run.
        if (sum_new == '0) begin
          tok_d.best = LenW'(idx_q + 1'b1);
        end else begin
          tok_d.srch = 1'b1;
        end
        tok_d.ovf = ovf_q;
      end else begin
        ovf_d     = 1'b1;
        tok_d.ovf = 1'b1;
      end
      if (last_i) begin
        sum_d = '0;
        idx_d = '0;
        ovf_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      idx_q <= '0;
      ovf_q <= 1'b0;
      tok_q <= '0;
    end else if (en_i) begin
      sum_q <= sum_d;
      idx_q <= idx_d;
      ovf_q <= ovf_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: hdl/lzsr_cell.sv
// ----------------------------------------------------------------------------
// lzsr_cell: one table entry of the prefix-sum table
// Compares the passing token against its stored sum, takes the sum if it is
// the first free entry, and drops its entry when the array's last element passes.
// ----------------------------------------------------------------------------
module lzsr_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  lzsr_pkg::lzsr_token_t tok_i,
  output lzsr_pkg::lzsr_token_t tok_o
);
  import lzsr_pkg::*;

  lzsr_token_t            tok_q, tok_d;
  logic                   ent_vld_q, ent_vld_d;
  logic signed [SumW-1:0] ent_sum_q, ent_sum_d;
  logic [PosW-1:0]        ent_pos_q, ent_pos_d;
  logic                   lookup;

  assign lookup = tok_i.vld && tok_i.srch && !tok_i.done;

  always_comb begin
    tok_d     = tok_i;
    ent_vld_d = ent_vld_q;
    ent_sum_d = ent_sum_q;
    ent_pos_d = ent_pos_q;
    if (lookup) begin
      // Entries fill in order, so the first free cell is where a new sum goes.
      if (!ent_vld_q) begin
        ent_vld_d  = 1'b1;
        ent_sum_d  = tok_i.sum;
        ent_pos_d  = tok_i.idx;
        tok_d.done = 1'b1;
      end else if (ent_sum_q == tok_i.sum) begin
        tok_d.done = 1'b1;
        tok_d.best = LenW'(tok_i.idx - ent_pos_q);
      end
    end
    // The last element sweeps the table clean for the array behind it.
    if (tok_i.vld && tok_i.last) begin
      ent_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q     <= '0;
      ent_vld_q <= 1'b0;
    end else if (en_i) begin
      tok_q     <= tok_d;
      ent_vld_q <= ent_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ent_sum_q <= ent_sum_d;
      ent_pos_q <= ent_pos_d;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: hdl/lzsr_tail.sv
// ----------------------------------------------------------------------------
// lzsr_tail: output stage
// Keeps the largest run length of the current array and presents the result
// when the last element leaves the cell row.
// ----------------------------------------------------------------------------
module lzsr_tail (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lzsr_pkg::lzsr_token_t             tok_i,
  output logic                              en_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lzsr_pkg::LenW-1:0]         best_length_o,
  output logic                              overflow_o
);
  import lzsr_pkg::*;

  logic [LenW-1:0] best_q, best_d;
  logic [LenW-1:0] cand;
  logic            out_vld_q, out_vld_d;
  logic [LenW-1:0] out_best_q, out_best_d;
  logic            out_ovf_q, out_ovf_d;
  logic            load;

  // The whole row advances only when the result register can take a result.
  assign en_o = !out_vld_q || out_ready_i;
  assign cand = (tok_i.best > best_q) ? tok_i.best : best_q;
  assign load = en_o && tok_i.vld && tok_i.last;

  always_comb begin
    best_d     = best_q;
    out_vld_d  = out_vld_q;
    out_best_d = out_best_q;
    out_ovf_d  = out_ovf_q;
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (en_o && tok_i.vld) begin
      best_d = cand;
    end
    if (load) begin
      out_vld_d  = 1'b1;
      out_best_d = cand;
      out_ovf_d  = tok_i.ovf;
      best_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      best_q    <= best_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_best_q <= out_best_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_valid_o   = out_vld_q;
  assign best_length_o = out_best_q;
  assign overflow_o    = out_ovf_q;

endmodule

FILE: hdl/longest_zero_sum_run.sv
// ----------------------------------------------------------------------------
// longest_zero_sum_run: longest contiguous zero-sum run of a streamed array
// Input channel: in_valid_i/in_ready_o with element_i (signed) and last_i,
// last_i marking the final element of an array. Output channel:
// out_valid_o/out_ready_i with best_length_o and overflow_o, one transaction
// per array, given for its last element.
// Each element becomes a token that walks a row of MaxLen cells, one cell per
// cycle while the row is not held; each cell holds one table entry (prefix
// sum and first position). A token either matches its cell's sum, claims the
// first free cell, or moves on; tokens trail each other by one cell, so a new
// element is accepted every cycle unless the row is held. The tail registers
// the result after the last element's token leaves the cell row.
// Elements past MaxLen in one array are dropped and set overflow_o.
// Reset empties the table and all counters; the block is ready right after.
// While a result waits on out_ready_i the whole row holds and in_ready_o is low.
// ----------------------------------------------------------------------------
module longest_zero_sum_run (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [lzsr_pkg::ElementBits-1:0] element_i,
  input  logic                                    last_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [lzsr_pkg::LenW-1:0]               best_length_o,
  output logic                                    overflow_o
);
  import lzsr_pkg::*;

  logic        en;
  lzsr_token_t tok [MaxLen+1];

  assign in_ready_o = en;

  lzsr_head u_head (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .element_i  (element_i),
    .last_i     (last_i),
    .tok_o      (tok[0])
  );

  for (genvar k = 0; k < MaxLen; k++) begin : g_cell
    lzsr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );
  end

  lzsr_tail u_tail (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tok_i         (tok[MaxLen]),
    .en_o          (en),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .best_length_o (best_length_o),
    .overflow_o    (overflow_o)
  );

endmodule

FILE: hdl/lzsr_checker.sv
// ----------------------------------------------------------------------------
// lzsr_checker: port-level checks for longest_zero_sum_run
// Watches the handshakes and result range at the top-level ports.
// ----------------------------------------------------------------------------
module lzsr_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    in_valid_i,
  input logic                                    in_ready_o,
  input logic signed [lzsr_pkg::ElementBits-1:0] element_i,
  input logic                                    last_i,
  input logic                                    out_valid_o,
  input logic                                    out_ready_i,
  input logic [lzsr_pkg::LenW-1:0]               best_length_o,
  input logic                                    overflow_o
);
  import lzsr_pkg::*;

  // A waiting input transaction keeps its payload until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(element_i)
                                  && $stable(last_i))
    else $error("input changed while waiting");

  // A stalled result holds its value until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(best_length_o)
                                    && $stable(overflow_o))
    else $error("result changed while stalled");

  // Input is blocked exactly while a result is held back.
  a_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while output stalled");

  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output register");

  // A run cannot be longer than the number of elements kept.
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> best_length_o <= LenW'(MaxLen))
    else $error("run length beyond array limit");

endmodule

bind longest_zero_sum_run lzsr_checker u_lzsr_checker (.*);
